>>> rtl/ipad_pkg.sv
// ----------------------------------------------------------------------------
// ipad_pkg
// Shared types, constants and the arctangent table for the I/Q to phase,
// amplitude and distance core.
// ----------------------------------------------------------------------------
package ipad_pkg;

   localparam int SAMPLE_WIDTH_DEF  = 16;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_ENTRIES      = 24;

   localparam int PHASE_W  = 12;
   localparam int AMP_W    = 16;
   localparam int DIST_W   = 24;
   localparam int SLOPE_W  = 32;
   localparam int OFFSET_W = 48;

   localparam logic signed [SLOPE_W-1:0]  SLOPE_RESET  = -32'sd54484;
   localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 48'sd257840946;

   localparam logic [31:0]                HALF_TURN = 32'h8000_0000;
   localparam logic signed [PHASE_W-1:0]  PHASE_MAX = 12'sd1800;
   localparam logic signed [DIST_W-1:0]   DIST_MAX  = 24'sd8388607;
   localparam logic signed [DIST_W-1:0]   DIST_MIN  = -24'sd8388608;

   typedef enum logic {
      CSR_SLOPE  = 1'b0,
      CSR_OFFSET = 1'b1
   } csr_index_type;

   // Control bits that travel with each word down the cell row.
   typedef struct packed {
      logic valid;
      logic zero;
      logic neg_axis;
   } ipad_flags_type;

   // atan(2^-i) as a binary angle, 2^32 per full turn
   function automatic logic [31:0] atan_angle(input int idx);
      logic [31:0] a;
      unique case (idx)
         0:       a = 32'h20000000;
         1:       a = 32'h12E4051E;
         2:       a = 32'h09FB385B;
         3:       a = 32'h051111D4;
         4:       a = 32'h028B0D43;
         5:       a = 32'h0145D7E1;
         6:       a = 32'h00A2F61E;
         7:       a = 32'h00517C55;
         8:       a = 32'h0028BE53;
         9:       a = 32'h00145F2F;
         10:      a = 32'h000A2F98;
         11:      a = 32'h000517CC;
         12:      a = 32'h00028BE6;
         13:      a = 32'h000145F3;
         14:      a = 32'h0000A2FA;
         15:      a = 32'h0000517D;
         16:      a = 32'h000028BE;
         17:      a = 32'h0000145F;
         18:      a = 32'h00000A30;
         19:      a = 32'h00000518;
         20:      a = 32'h0000028C;
         21:      a = 32'h00000146;
         22:      a = 32'h000000A3;
         23:      a = 32'h00000051;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

>>> rtl/iq_to_phase_amplitude_distance_core.sv
// ----------------------------------------------------------------------------
// iq_to_phase_amplitude_distance_core
// CORDIC vectoring phase, rounded magnitude and linear distance per sample.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one complex sample per word: in_phase in the low
//   SAMPLE_WIDTH bits of req_tdata, quadrature right above it.
//   rsp_* returns one word per sample, in order: phase in tenths of a
//   degree, rounded amplitude and the saturated Q4 distance.
//   csr_* writes the Q16 slope (index 0) and offset (index 1); write only
//   while no sample is in flight.
// Throughput: one sample per cycle while the output is not stalled, in a
//   row of max(CORDIC_STAGES, SAMPLE_WIDTH) cells, each doing at most one
//   micro-rotation and one square-root digit.
// Pipeline: three front stages, the cells, four back stages and the
//   result register lie between acceptance and rsp_tvalid.
// Stall: the whole pipeline holds while a result waits and rsp_tready is
//   low; req_tready follows, so a new word enters whenever the result
//   register is empty or being taken.
// Reset: clears all valid bits and loads the reset slope and offset;
//   req_tready stays low while reset is high.
// ----------------------------------------------------------------------------
module iq_to_phase_amplitude_distance_core #(
   parameter int SAMPLE_WIDTH  = ipad_pkg::SAMPLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = ipad_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // [SAMPLE_WIDTH-1:0] in_phase, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] quadrature
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [11:0] phase_tenths, [27:12] amplitude, [51:28] distance_q4
   output logic [55:0]                            rsp_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_we,
   input  ipad_pkg::csr_index_type                csr_addr,
   input  logic [ipad_pkg::OFFSET_W-1:0]          csr_wdata
);
   import ipad_pkg::*;

   localparam int XW    = SAMPLE_WIDTH + 10;
   localparam int NW    = 2 * SAMPLE_WIDTH;
   localparam int NCELL = (CORDIC_STAGES > SAMPLE_WIDTH) ? CORDIC_STAGES : SAMPLE_WIDTH;
   localparam int RSP_PAD = 56 - (PHASE_W + AMP_W + DIST_W);

   logic signed [SLOPE_W-1:0]  slope_ff;
   logic signed [OFFSET_W-1:0] offset_ff;

   logic adv;

   ipad_flags_type       flags_c [NCELL+1];
   logic signed [XW-1:0] x_c     [NCELL+1];
   logic signed [XW-1:0] y_c     [NCELL+1];
   logic [31:0]          z_c     [NCELL+1];
   logic [NW-1:0]        rem_c   [NCELL+1];
   logic [NW-1:0]        root_c  [NCELL+1];

   logic                      out_valid;
   logic signed [PHASE_W-1:0] out_phase;
   logic [AMP_W-1:0]          out_amp;
   logic signed [DIST_W-1:0]  out_dist;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff  <= SLOPE_RESET;
         offset_ff <= OFFSET_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SLOPE:  slope_ff  <= csr_wdata[SLOPE_W-1:0];
            CSR_OFFSET: offset_ff <= csr_wdata;
         endcase
      end
   end

   // advance everything unless a finished word is stuck at the output
   assign adv        = !out_valid || rsp_tready;
   assign req_tready = adv && !reset;

   ipad_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .re_in     (req_tdata[SAMPLE_WIDTH-1:0]),
      .im_in     (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .flags_out (flags_c[0]),
      .x_out     (x_c[0]),
      .y_out     (y_c[0]),
      .z_out     (z_c[0]),
      .n_out     (rem_c[0])
   );

   assign root_c[0] = '0;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      ipad_cell #(
         .SAMPLE_WIDTH  (SAMPLE_WIDTH),
         .CORDIC_STAGES (CORDIC_STAGES),
         .STAGE         (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .flags_in  (flags_c[k]),
         .x_in      (x_c[k]),
         .y_in      (y_c[k]),
         .z_in      (z_c[k]),
         .rem_in    (rem_c[k]),
         .root_in   (root_c[k]),
         .flags_out (flags_c[k+1]),
         .x_out     (x_c[k+1]),
         .y_out     (y_c[k+1]),
         .z_out     (z_c[k+1]),
         .rem_out   (rem_c[k+1]),
         .root_out  (root_c[k+1])
      );
   end

   ipad_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .flags_in  (flags_c[NCELL]),
      .z_in      (z_c[NCELL]),
      .rem_in    (rem_c[NCELL]),
      .root_in   (root_c[NCELL]),
      .slope     (slope_ff),
      .offset    (offset_ff),
      .out_valid (out_valid),
      .out_phase (out_phase),
      .out_amp   (out_amp),
      .out_dist  (out_dist)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, out_dist, out_amp, out_phase};

   a_phase_range : assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_phase <= PHASE_MAX) && (out_phase >= -PHASE_MAX))
      else $error("phase outside +/-1800 tenths");

   a_zero_amp_phase : assert property (@(posedge clock) disable iff (reset)
      out_valid && (out_amp == '0) |-> (out_phase == '0))
      else $error("zero amplitude with nonzero phase");

   a_slope_write : assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_addr == CSR_SLOPE) |=> slope_ff == $past(csr_wdata[SLOPE_W-1:0]))
      else $error("slope register not loaded");

endmodule

>>> rtl/ipad_front.sv
// ----------------------------------------------------------------------------
// ipad_front
// Input capture, squaring and CORDIC pre-rotation ahead of the cell row.
// ----------------------------------------------------------------------------
module ipad_front #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  logic                                   in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0]         re_in,
   input  logic signed [SAMPLE_WIDTH-1:0]         im_in,
   output ipad_pkg::ipad_flags_type               flags_out,
   output logic signed [SAMPLE_WIDTH+9:0]         x_out,
   output logic signed [SAMPLE_WIDTH+9:0]         y_out,
   output logic [31:0]                            z_out,
   output logic [2*SAMPLE_WIDTH-1:0]              n_out
);
   import ipad_pkg::*;

   localparam int XW = SAMPLE_WIDTH + 10;
   localparam int NW = 2 * SAMPLE_WIDTH;

   // capture stage
   logic                           f0_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] re_ff;
   logic signed [SAMPLE_WIDTH-1:0] im_ff;

   // square stage
   ipad_flags_type     f1_flags_ff, f1_flags_in;
   logic signed [NW-1:0] sq_re_in, sq_im_in;
   logic [NW-1:0]      sq_re_ff, sq_im_ff;
   logic signed [XW-1:0] x1_ff, x1_in, y1_ff, y1_in, x_pre, y_pre;
   logic [31:0]        z1_ff, z1_in;

   // sum stage
   ipad_flags_type     f2_flags_ff;
   logic signed [XW-1:0] x2_ff, y2_ff;
   logic [31:0]        z2_ff;
   logic [NW-1:0]      n2_ff, n2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
      end else if (adv) begin
         f0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

   always_comb begin
      f1_flags_in.valid    = f0_valid_ff;
      f1_flags_in.zero     = (re_ff == '0) && (im_ff == '0);
      f1_flags_in.neg_axis = (im_ff == '0) && re_ff[SAMPLE_WIDTH-1];
      sq_re_in = re_ff * re_ff;
      sq_im_in = im_ff * im_ff;
      x_pre = {{(XW-SAMPLE_WIDTH-8){re_ff[SAMPLE_WIDTH-1]}}, re_ff, 8'h00};
      y_pre = {{(XW-SAMPLE_WIDTH-8){im_ff[SAMPLE_WIDTH-1]}}, im_ff, 8'h00};
      // left half plane: turn by a half turn first
      if (re_ff[SAMPLE_WIDTH-1]) begin
         x1_in = -x_pre;
         y1_in = -y_pre;
         z1_in = HALF_TURN;
      end else begin
         x1_in = x_pre;
         y1_in = y_pre;
         z1_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_flags_ff <= '0;
         f2_flags_ff <= '0;
      end else if (adv) begin
         f1_flags_ff <= f1_flags_in;
         f2_flags_ff <= f1_flags_ff;
      end
   end

   assign n2_in = sq_re_ff + sq_im_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_re_ff <= sq_re_in;
         sq_im_ff <= sq_im_in;
         x1_ff    <= x1_in;
         y1_ff    <= y1_in;
         z1_ff    <= z1_in;
         n2_ff    <= n2_in;
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         z2_ff    <= z1_ff;
      end
   end

   assign flags_out = f2_flags_ff;
   assign x_out     = x2_ff;
   assign y_out     = y2_ff;
   assign z_out     = z2_ff;
   assign n_out     = n2_ff;

endmodule

>>> rtl/ipad_cell.sv
// ----------------------------------------------------------------------------
// ipad_cell
// One cell of the row: a CORDIC vectoring micro-rotation and one digit of
// restoring square root where STAGE is in range, registered to the next cell.
// ----------------------------------------------------------------------------
module ipad_cell #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int CORDIC_STAGES = 16,
   parameter int STAGE         = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  ipad_pkg::ipad_flags_type        flags_in,
   input  logic signed [SAMPLE_WIDTH+9:0]  x_in,
   input  logic signed [SAMPLE_WIDTH+9:0]  y_in,
   input  logic [31:0]                     z_in,
   input  logic [2*SAMPLE_WIDTH-1:0]       rem_in,
   input  logic [2*SAMPLE_WIDTH-1:0]       root_in,
   output ipad_pkg::ipad_flags_type        flags_out,
   output logic signed [SAMPLE_WIDTH+9:0]  x_out,
   output logic signed [SAMPLE_WIDTH+9:0]  y_out,
   output logic [31:0]                     z_out,
   output logic [2*SAMPLE_WIDTH-1:0]       rem_out,
   output logic [2*SAMPLE_WIDTH-1:0]       root_out
);
   import ipad_pkg::*;

   localparam int XW = SAMPLE_WIDTH + 10;
   localparam int NW = 2 * SAMPLE_WIDTH;

   localparam bit ROTATE_ON = (STAGE < CORDIC_STAGES) && (STAGE < ATAN_ENTRIES);
   localparam bit ROOT_ON   = (STAGE < SAMPLE_WIDTH);
   localparam int ROOT_SHIFT = ROOT_ON ? 2 * (SAMPLE_WIDTH - 1 - STAGE) : 0;
   localparam logic [NW-1:0] ROOT_BIT = {{(NW-1){1'b0}}, 1'b1} << ROOT_SHIFT;
   localparam logic [31:0]   ATAN     = atan_angle(STAGE);

   ipad_flags_type        flags_ff;
   logic signed [XW-1:0]  x_ff, x_in_n, y_ff, y_in_n, dx, dy;
   logic [31:0]           z_ff, z_in_n;
   logic [NW-1:0]         rem_ff, rem_in_n, root_ff, root_in_n, trial;
   logic                  y_pos;

   always_comb begin
      dx    = y_in >>> STAGE;
      dy    = x_in >>> STAGE;
      y_pos = !y_in[XW-1] && (y_in != '0);
      x_in_n = x_in;
      y_in_n = y_in;
      z_in_n = z_in;
      if (ROTATE_ON) begin
         // drive y toward zero
         if (y_pos) begin
            x_in_n = x_in + dx;
            y_in_n = y_in - dy;
            z_in_n = z_in + ATAN;
         end else begin
            x_in_n = x_in - dx;
            y_in_n = y_in + dy;
            z_in_n = z_in - ATAN;
         end
      end
   end

   always_comb begin
      trial     = root_in + ROOT_BIT;
      rem_in_n  = rem_in;
      root_in_n = root_in;
      if (ROOT_ON) begin
         if (rem_in >= trial) begin
            rem_in_n  = rem_in - trial;
            root_in_n = (root_in >> 1) + ROOT_BIT;
         end else begin
            root_in_n = root_in >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (adv) begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff    <= x_in_n;
         y_ff    <= y_in_n;
         z_ff    <= z_in_n;
         rem_ff  <= rem_in_n;
         root_ff <= root_in_n;
      end
   end

   assign flags_out = flags_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;

endmodule

>>> rtl/ipad_back.sv
// ----------------------------------------------------------------------------
// ipad_back
// Angle to tenths of a degree, magnitude rounding and the distance map,
// ending in the result register.
// ----------------------------------------------------------------------------
module ipad_back #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        adv,
   input  ipad_pkg::ipad_flags_type                    flags_in,
   input  logic [31:0]                                 z_in,
   input  logic [2*SAMPLE_WIDTH-1:0]                   rem_in,
   input  logic [2*SAMPLE_WIDTH-1:0]                   root_in,
   input  logic signed [ipad_pkg::SLOPE_W-1:0]         slope,
   input  logic signed [ipad_pkg::OFFSET_W-1:0]        offset,
   output logic                                        out_valid,
   output logic signed [ipad_pkg::PHASE_W-1:0]         out_phase,
   output logic [ipad_pkg::AMP_W-1:0]                  out_amp,
   output logic signed [ipad_pkg::DIST_W-1:0]          out_dist
);
   import ipad_pkg::*;

   localparam int RW = (SAMPLE_WIDTH + 1 > AMP_W) ? SAMPLE_WIDTH + 1 : AMP_W;
   localparam logic [RW-1:0]         AMP_LIMIT   = RW'({AMP_W{1'b1}});
   localparam logic signed [43:0]    PHASE_SCALE = 44'sd3600;
   localparam logic signed [44:0]    HALF_LSB    = 45'sd2147483648;
   localparam logic signed [12:0]    PH_HI       = 13'sd1800;
   localparam logic signed [12:0]    PH_LO       = -13'sd1800;
   localparam logic signed [49:0]    DIST_ROUND  = 50'sd2048;

   // B1: angle product, amplitude rounding
   ipad_flags_type        b1_flags_ff;
   logic signed [43:0]    zprod_ff, zprod_in;
   logic [RW-1:0]         root_rnd;
   logic [AMP_W-1:0]      b1_amp_ff, b1_amp_in;

   // B2: phase
   logic                  b2_valid_ff;
   logic signed [44:0]    zsum;
   logic signed [12:0]    tnum;
   logic signed [PHASE_W-1:0] b2_ph_ff, b2_ph_in;
   logic [AMP_W-1:0]      b2_amp_ff;

   // B3: slope product
   logic                  b3_valid_ff;
   logic signed [43:0]    dprod_ff, dprod_in;
   logic signed [PHASE_W-1:0] b3_ph_ff;
   logic [AMP_W-1:0]      b3_amp_ff;

   // B4: offset add and Q4 rounding
   logic                  b4_valid_ff;
   logic signed [49:0]    dsum;
   logic signed [37:0]    q_ff;
   logic signed [PHASE_W-1:0] b4_ph_ff;
   logic [AMP_W-1:0]      b4_amp_ff;

   // result register
   logic                      out_valid_ff;
   logic signed [PHASE_W-1:0] out_ph_ff;
   logic [AMP_W-1:0]          out_amp_ff;
   logic signed [DIST_W-1:0]  out_dist_ff, dist_in;

   always_comb begin
      zprod_in = $signed({{12{z_in[31]}}, z_in}) * PHASE_SCALE;
      root_rnd = RW'(root_in[SAMPLE_WIDTH-1:0]) + RW'(rem_in > root_in);
      if (root_rnd > AMP_LIMIT) begin
         b1_amp_in = {AMP_W{1'b1}};
      end else begin
         b1_amp_in = root_rnd[AMP_W-1:0];
      end
   end

   always_comb begin
      zsum = $signed({zprod_ff[43], zprod_ff}) + HALF_LSB;
      tnum = zsum[44:32];
      priority if (b1_flags_ff.zero) begin
         b2_ph_in = '0;
      end else if (b1_flags_ff.neg_axis) begin
         b2_ph_in = PHASE_MAX;
      end else if (tnum > PH_HI) begin
         b2_ph_in = PHASE_MAX;
      end else if (tnum < PH_LO) begin
         b2_ph_in = -PHASE_MAX;
      end else begin
         b2_ph_in = tnum[PHASE_W-1:0];
      end
   end

   assign dprod_in = $signed({{12{slope[SLOPE_W-1]}}, slope})
                   * $signed({{(44-PHASE_W){b2_ph_ff[PHASE_W-1]}}, b2_ph_ff});

   assign dsum = $signed({{2{offset[OFFSET_W-1]}}, offset})
               + $signed({{6{dprod_ff[43]}}, dprod_ff}) + DIST_ROUND;

   always_comb begin
      priority if (q_ff > 38'(DIST_MAX)) begin
         dist_in = DIST_MAX;
      end else if (q_ff < 38'(DIST_MIN)) begin
         dist_in = DIST_MIN;
      end else begin
         dist_in = q_ff[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_flags_ff  <= '0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_flags_ff  <= flags_in;
         b2_valid_ff  <= b1_flags_ff.valid;
         b3_valid_ff  <= b2_valid_ff;
         b4_valid_ff  <= b3_valid_ff;
         out_valid_ff <= b4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zprod_ff    <= zprod_in;
         b1_amp_ff   <= b1_amp_in;
         b2_ph_ff    <= b2_ph_in;
         b2_amp_ff   <= b1_amp_ff;
         dprod_ff    <= dprod_in;
         b3_ph_ff    <= b2_ph_ff;
         b3_amp_ff   <= b2_amp_ff;
         q_ff        <= dsum[49:12];
         b4_ph_ff    <= b3_ph_ff;
         b4_amp_ff   <= b3_amp_ff;
         out_ph_ff   <= b4_ph_ff;
         out_amp_ff  <= b4_amp_ff;
         out_dist_ff <= dist_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_phase = out_ph_ff;
   assign out_amp   = out_amp_ff;
   assign out_dist  = out_dist_ff;

endmodule
